[rtl/core/apsc_pkg.sv]
// ----------------------------------------------------------------------------
// apsc_pkg
// Shared types and constants for the archive path safety checker.
// ----------------------------------------------------------------------------
package apsc_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int KEPT_W   = 17;
    localparam int REASON_W = 3;
    localparam int CLEN_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [KEPT_W-1:0] KEPT_MAX = 17'h10000;

    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;

    localparam logic [REASON_W-1:0] REASON_SAFE  = 3'd0;
    localparam logic [REASON_W-1:0] REASON_EMPTY = 3'd1;
    localparam logic [REASON_W-1:0] REASON_LONG  = 3'd2;
    localparam logic [REASON_W-1:0] REASON_SLASH = 3'd3;
    localparam logic [REASON_W-1:0] REASON_COMP  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_MODE = 1'd1;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd4096;

    typedef struct packed {
        logic [BYTE_W-1:0] path_byte;
        logic              has_byte;
        logic              last;
    } apsc_item_t;

    typedef struct packed {
        logic                unsafe;
        logic [REASON_W-1:0] reason;
        logic [KEPT_W-1:0]   kept_length;
    } apsc_verdict_t;

    typedef struct packed {
        logic              in_prefix;
        logic [CLEN_W-1:0] component_len;
        logic              component_all_dots;
        logic [KEPT_W-1:0] kept_count;
        logic              seen_leading_slash;
        logic              seen_bad_component;
        logic              ended_by_nul;
    } apsc_state_t;

    localparam apsc_state_t STATE_CLEAR = '{
        in_prefix:          1'b1,
        component_len:      '0,
        component_all_dots: 1'b1,
        kept_count:         '0,
        seen_leading_slash: 1'b0,
        seen_bad_component: 1'b0,
        ended_by_nul:       1'b0
    };

    function automatic logic [KEPT_W-1:0] sat_inc(input logic [KEPT_W-1:0] v);
        sat_inc = (v < KEPT_MAX) ? v + 1'b1 : v;
    endfunction

    function automatic logic comp_bad(input logic [CLEN_W-1:0] clen,
                                      input logic dots, input logic link);
        if (link)
            comp_bad = dots && (clen == 2'd2);
        else
            comp_bad = (clen == 2'd0) || (dots && (clen == 2'd1 || clen == 2'd2));
    endfunction

endpackage

[rtl/core/apsc_if.sv]
// ----------------------------------------------------------------------------
// apsc interfaces
// Valid/ready channels for path bytes, verdicts and register writes.
// ----------------------------------------------------------------------------
interface apsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] path_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output path_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input path_byte, input has_byte, input last,
                    output ready);
endinterface

interface apsc_out_if;
    logic        valid;
    logic        ready;
    logic        unsafe;
    logic [2:0]  reason;
    logic [16:0] kept_length;

    modport source (output valid, output unsafe, output reason, output kept_length,
                    input ready);
    modport sink   (input valid, input unsafe, input reason, input kept_length,
                    output ready);
endinterface

interface apsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/archive_path_safety_checker.sv]
// ----------------------------------------------------------------------------
// archive_path_safety_checker
// Checks a path string, one byte per request, and gives a verdict on the
// request marked last.
//
//   channel  dir  carries
//   in_ch    in   path_byte, has_byte, last
//   out_ch   out  unsafe, reason, kept_length (one per last request)
//   cfg_ch   in   index, data (0: max_len, 1: link_mode)
//
// One byte per cycle sustained while no verdict stalls. A request is held
// in the input register, where the scan logic updates the running state;
// a last request's verdict goes into the output register as it advances.
// Reset restores max_len 4096, entry mode and clear path state. A stalled
// verdict holds only a request marked last, and later bytes wait behind it.
// ----------------------------------------------------------------------------
module archive_path_safety_checker
(
    input  logic       clk,
    input  logic       rst_n,
    apsc_in_if.sink    in_ch,
    apsc_out_if.source out_ch,
    apsc_cfg_if.sink   cfg_ch
);
    import apsc_pkg::*;

    apsc_item_t    in_item_reg;
    logic          in_valid_reg;
    apsc_verdict_t out_reg;
    logic          out_valid_reg;
    logic [15:0]   max_len_reg;
    logic          link_mode_reg;
    apsc_verdict_t verdict;
    logic          advance;
    logic          load_out;

    assign load_out  = in_valid_reg && in_item_reg.last;
    assign advance   = in_valid_reg && (!in_item_reg.last || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            link_mode_reg <= 1'b0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_MAX_LEN:   max_len_reg   <= cfg_ch.data;
                CFG_LINK_MODE: link_mode_reg <= cfg_ch.data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_item_reg.path_byte <= in_ch.path_byte;
            in_item_reg.has_byte  <= in_ch.has_byte;
            in_item_reg.last      <= in_ch.last;
        end
    end

    apsc_scan u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .max_len   (max_len_reg),
        .link_mode (link_mode_reg),
        .verdict   (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && load_out)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_out)
            out_reg <= verdict;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.unsafe      = out_reg.unsafe;
    assign out_ch.reason      = out_reg.reason;
    assign out_ch.kept_length = out_reg.kept_length;

endmodule

[rtl/core/apsc_scan.sv]
// ----------------------------------------------------------------------------
// apsc_scan
// Running path state: prefix stripping, component checks, length count, and
// the verdict for the request marked last.
// ----------------------------------------------------------------------------
module apsc_scan
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  apsc_pkg::apsc_item_t    item,
    input  logic [15:0]             max_len,
    input  logic                    link_mode,
    output apsc_pkg::apsc_verdict_t verdict
);
    import apsc_pkg::*;

    apsc_state_t state_reg;
    apsc_state_t state_next;

    always_comb
    begin
        apsc_state_t s;
        apsc_state_t f;
        logic        pending;
        logic        held;
        logic        is_slash;
        logic        is_dot;

        s        = state_reg;
        is_slash = (item.path_byte == CHAR_SLASH);
        is_dot   = (item.path_byte == CHAR_DOT);
        pending  = s.in_prefix && (s.component_len == 2'd1);
        held     = 1'b0;

        if (item.has_byte && !s.ended_by_nul)
        begin
            if (item.path_byte == CHAR_NUL)
            begin
                s.ended_by_nul = 1'b1;
            end
            else
            begin
                if (s.in_prefix && !link_mode && !pending && is_dot)
                begin
                    s.component_len      = 2'd1;
                    s.component_all_dots = 1'b1;
                    held                 = 1'b1;
                end
                else if (s.in_prefix && !link_mode && pending && is_slash)
                begin
                    s.component_len      = 2'd0;
                    s.component_all_dots = 1'b1;
                    held                 = 1'b1;
                end

                if (!held)
                begin
                    if (s.in_prefix)
                    begin
                        s.in_prefix = 1'b0;
                        if (pending)
                            s.kept_count = sat_inc(s.kept_count);
                        else if (is_slash)
                            s.seen_leading_slash = 1'b1;
                    end
                    s.kept_count = sat_inc(s.kept_count);
                    if (is_slash)
                    begin
                        if (comp_bad(s.component_len, s.component_all_dots, link_mode))
                            s.seen_bad_component = 1'b1;
                        s.component_len      = 2'd0;
                        s.component_all_dots = 1'b1;
                    end
                    else
                    begin
                        if (s.component_len != 2'd3)
                            s.component_len = s.component_len + 2'd1;
                        if (!is_dot)
                            s.component_all_dots = 1'b0;
                    end
                end
            end
        end

        state_next = item.last ? STATE_CLEAR : s;

        // end of string: count a held dot, close the open component
        f = s;
        if (f.in_prefix && (f.component_len == 2'd1))
            f.kept_count = sat_inc(f.kept_count);
        if (comp_bad(f.component_len, f.component_all_dots, link_mode))
            f.seen_bad_component = 1'b1;

        if (f.kept_count == '0)
            verdict.reason = REASON_EMPTY;
        else if (f.kept_count > {1'b0, max_len})
            verdict.reason = REASON_LONG;
        else if (f.seen_leading_slash)
            verdict.reason = REASON_SLASH;
        else if (f.seen_bad_component)
            verdict.reason = REASON_COMP;
        else
            verdict.reason = REASON_SAFE;
        verdict.unsafe      = (verdict.reason != REASON_SAFE);
        verdict.kept_length = f.kept_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_CLEAR;
        else if (step)
            state_reg <= state_next;
    end

endmodule

[tb/sv/tb_archive_path_safety_checker.sv]
// ----------------------------------------------------------------------------
// tb_archive_path_safety_checker
// Feeds path strings one byte per request, with bursty input and a stalling
// verdict side, and checks every verdict against an in-bench scan of the path
// or a typed row's tabled verdict. A short table of directed requests and
// register writes comes first, then random strings over several settings.
// ----------------------------------------------------------------------------
module tb_archive_path_safety_checker;

    import apsc_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int DRAIN_CYCLES    = 4;
    localparam int RANDOM_ITEMS    = 2000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int END_WAIT_CYCLES = 20000;
    localparam int MAX_REPORTS     = 60;
    localparam int LIMIT_TIME      = 3000000;
    localparam int DIR_ROWS        = 31;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic                  has_byte;
        logic                  last;
        logic                  typed;
        apsc_verdict_t         want;
    } dir_row_t;

    localparam apsc_verdict_t NO_WANT = '0;

    localparam logic [CFG_DATA_W-1:0] V_NUL   = {8'h00, CHAR_NUL};
    localparam logic [CFG_DATA_W-1:0] V_DOT   = {8'h00, CHAR_DOT};
    localparam logic [CFG_DATA_W-1:0] V_SLASH = {8'h00, CHAR_SLASH};

    logic clk = 1'b0;
    logic rst_n;

    apsc_in_if  in_ch();
    apsc_out_if out_ch();
    apsc_cfg_if cfg_ch();

    archive_path_safety_checker uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // scan state, mirrors the block
    logic              at_start   = 1'b1;
    logic [CLEN_W-1:0] seg_len    = '0;
    logic              seg_dots   = 1'b1;
    logic [KEPT_W-1:0] kept       = '0;
    logic              lead_slash = 1'b0;
    logic              bad_seg    = 1'b0;
    logic              nul_seen   = 1'b0;
    logic [LEN_W-1:0]  len_limit  = MAX_LEN_RESET;
    logic              link_rules = 1'b0;

    apsc_verdict_t  verdicts_due [$];
    logic [7:0]     path_bytes [$];
    int             mismatch_count = 0;
    int             verdicts_seen  = 0;
    int             items_sent     = 0;
    int             burst_left     = 0;
    bit             hold_off_req   = 1'b0;
    logic           row_typed;
    apsc_verdict_t  row_want;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_REQ, '0, 16'h00A5, 1'b0, 1'b1, 1'b1, '{1'b1, REASON_EMPTY, 17'd0}},
        '{ROW_REQ, '0, V_SLASH, 1'b1, 1'b1, 1'b1, '{1'b1, REASON_SLASH, 17'd1}},
        '{ROW_REQ, '0, V_DOT, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_REQ, '0, V_SLASH, 1'b1, 1'b1, 1'b1, '{1'b1, REASON_EMPTY, 17'd0}},
        '{ROW_REQ, '0, V_DOT, 1'b1, 1'b1, 1'b0, NO_WANT},
        '{ROW_REQ, '0, V_DOT, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_REQ, '0, V_DOT, 1'b1, 1'b1, 1'b0, NO_WANT},
        '{ROW_REQ, '0, 16'h0061, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_REQ, '0, V_SLASH, 1'b1, 1'b1, 1'b0, NO_WANT},
        '{ROW_REQ, '0, 16'h0061, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_REQ, '0, V_NUL, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_REQ, '0, 16'h00FF, 1'b1, 1'b1, 1'b0, NO_WANT},
        '{ROW_REQ, '0, 16'h00FF, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_REQ, '0, 16'h00A5, 1'b0, 1'b1, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_MAX_LEN, 16'd0, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_REQ, '0, 16'h0061, 1'b1, 1'b1, 1'b1, '{1'b1, REASON_LONG, 17'd1}},
        '{ROW_CFG, CFG_MAX_LEN, 16'd1, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_REQ, '0, V_DOT, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_REQ, '0, V_SLASH, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_REQ, '0, 16'h0062, 1'b1, 1'b1, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_MAX_LEN, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_LINK_MODE, 16'd1, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_REQ, '0, V_DOT, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_REQ, '0, V_SLASH, 1'b1, 1'b1, 1'b0, NO_WANT},
        '{ROW_REQ, '0, V_DOT, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_REQ, '0, V_DOT, 1'b1, 1'b1, 1'b0, NO_WANT},
        '{ROW_REQ, '0, 16'h0061, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_REQ, '0, V_SLASH, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_REQ, '0, V_SLASH, 1'b1, 1'b1, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_LINK_MODE, 16'd0, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_MAX_LEN, MAX_LEN_RESET, 1'b0, 1'b0, 1'b0, NO_WANT}
    };

    task automatic log_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void bump_kept();
        if (kept < KEPT_MAX)
            kept = kept + 1'b1;
    endfunction

    function automatic void end_segment();
        logic bad;
        if (link_rules)
            bad = seg_dots && seg_len == 2'd2;
        else
            bad = seg_len == 2'd0 || (seg_dots && (seg_len == 2'd1 || seg_len == 2'd2));
        if (bad)
            bad_seg = 1'b1;
        seg_len  = '0;
        seg_dots = 1'b1;
    endfunction

    function automatic void scan_byte(input logic [7:0] b);
        logic dot_held;
        if (nul_seen)
            return;
        if (b == CHAR_NUL)
        begin
            nul_seen = 1'b1;
            return;
        end
        if (at_start)
        begin
            dot_held = seg_len == 2'd1;
            if (!link_rules && !dot_held && b == CHAR_DOT)
            begin
                seg_len  = 2'd1;
                seg_dots = 1'b1;
                return;
            end
            if (!link_rules && dot_held && b == CHAR_SLASH)
            begin
                seg_len  = '0;
                seg_dots = 1'b1;
                return;
            end
            at_start = 1'b0;
            if (dot_held)
                bump_kept();
            else if (b == CHAR_SLASH)
                lead_slash = 1'b1;
        end
        bump_kept();
        if (b == CHAR_SLASH)
            end_segment();
        else
        begin
            if (seg_len != 2'd3)
                seg_len = seg_len + 1'b1;
            if (b != CHAR_DOT)
                seg_dots = 1'b0;
        end
    endfunction

    function automatic apsc_verdict_t give_verdict();
        apsc_verdict_t v;
        if (at_start && seg_len == 2'd1)
            bump_kept();
        end_segment();
        if (kept == 0)
            v.reason = REASON_EMPTY;
        else if (kept > {1'b0, len_limit})
            v.reason = REASON_LONG;
        else if (lead_slash)
            v.reason = REASON_SLASH;
        else if (bad_seg)
            v.reason = REASON_COMP;
        else
            v.reason = REASON_SAFE;
        v.unsafe      = v.reason != REASON_SAFE;
        v.kept_length = kept;
        at_start   = 1'b1;
        seg_len    = '0;
        seg_dots   = 1'b1;
        kept       = '0;
        lead_slash = 1'b0;
        bad_seg    = 1'b0;
        nul_seen   = 1'b0;
        return v;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        apsc_verdict_t calc;
        apsc_verdict_t want;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            if (in_ch.has_byte)
                scan_byte(in_ch.path_byte);
            if (in_ch.last)
            begin
                calc = give_verdict();
                verdicts_due = {verdicts_due, (row_typed ? row_want : calc)};
            end
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (verdicts_due.size() == 0)
                log_mismatch("verdict with none due");
            else
            begin
                want = verdicts_due.pop_front();
                if (out_ch.unsafe !== want.unsafe)
                    log_mismatch($sformatf("verdict %0d unsafe got %b want %b",
                                           verdicts_seen, out_ch.unsafe, want.unsafe));
                if (out_ch.reason !== want.reason)
                    log_mismatch($sformatf("verdict %0d reason got %0d want %0d",
                                           verdicts_seen, out_ch.reason, want.reason));
                if (out_ch.kept_length !== want.kept_length)
                    log_mismatch($sformatf("verdict %0d kept_length got %0d want %0d",
                                           verdicts_seen, out_ch.kept_length,
                                           want.kept_length));
            end
            verdicts_seen++;
        end
    end

    // verdict side: stall pattern changes every stretch; one long hold-off on demand
    initial
    begin : verdict_sink
        int span;
        int pct;
        out_ch.ready = 1'b0;
        forever
        begin
            span = $urandom_range(16, 160);
            case ($urandom_range(0, 3))
                0:       pct = 100;
                1:       pct = 60;
                2:       pct = 30;
                default: pct = 8;
            endcase
            repeat (span)
            begin
                @(negedge clk);
                if (hold_off_req)
                begin
                    hold_off_req = 1'b0;
                    out_ch.ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge clk);
                end
                out_ch.ready <= ($urandom_range(1, 100) <= pct);
            end
        end
    end

    task automatic put_req(input logic [7:0] b, input logic hb, input logic lst,
                           input logic typed = 1'b0, input apsc_verdict_t want = '0);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0)
            begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        if (burst_left != 0)
            burst_left--;
        @(negedge clk);
        in_ch.valid     <= 1'b1;
        in_ch.path_byte <= b;
        in_ch.has_byte  <= hb;
        in_ch.last      <= lst;
        row_typed       <= typed;
        row_want        <= want;
        do @(posedge clk); while (!in_ch.ready);
        if (hb || lst)
            items_sent++;
    endtask

    // input quiet, every verdict back, pipeline drained
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == CFG_MAX_LEN)
            len_limit = val;
        else
            link_rules = val[0];
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic add_byte(input logic [7:0] b);
        path_bytes = {path_bytes, b};
    endtask

    // mostly well-formed paths: "./" prefixes, dot components, names; rest is noise
    task automatic compose_path();
        int parts;
        int i;
        path_bytes.delete();
        if ($urandom_range(0, 99) < 75)
        begin
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3))
                begin
                    add_byte(CHAR_DOT);
                    add_byte(CHAR_SLASH);
                end
            if ($urandom_range(0, 9) == 0)
                add_byte(CHAR_SLASH);
            parts = $urandom_range(1, 4);
            for (i = 0; i < parts; i++)
            begin
                if (i > 0)
                    add_byte(CHAR_SLASH);
                case ($urandom_range(0, 9))
                    0: ;
                    1: add_byte(CHAR_DOT);
                    2: repeat (2) add_byte(CHAR_DOT);
                    3: repeat (3) add_byte(CHAR_DOT);
                    default:
                        repeat ($urandom_range(1, 6))
                            case ($urandom_range(0, 9))
                                0:       add_byte(CHAR_DOT);
                                1:       add_byte(8'($urandom_range(1, 255)));
                                default: add_byte(8'($urandom_range(8'h61, 8'h7A)));
                            endcase
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                add_byte(CHAR_SLASH);
            if ($urandom_range(0, 14) == 0)
            begin
                add_byte(CHAR_NUL);
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
            end
        end
        else
            repeat ($urandom_range(0, 10))
                case ($urandom_range(0, 3))
                    0:       add_byte(CHAR_DOT);
                    1:       add_byte(CHAR_SLASH);
                    2:       add_byte(CHAR_NUL);
                    default: add_byte(8'($urandom_range(0, 255)));
                endcase
    endtask

    task automatic send_path(input bit close);
        int i;
        bit blank_tail;
        blank_tail = path_bytes.size() == 0 || $urandom_range(0, 7) == 0;
        for (i = 0; i < path_bytes.size(); i++)
        begin
            if ($urandom_range(0, 11) == 0)
                put_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            put_req(path_bytes[i], 1'b1, close && !blank_tail && i == path_bytes.size() - 1);
        end
        if (close && blank_tail)
            put_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial
    begin : stimulus
        int n;
        int phase;
        int phase_end;
        logic [LEN_W-1:0] lim;
        in_ch.valid     = 1'b0;
        in_ch.path_byte = '0;
        in_ch.has_byte  = 1'b0;
        in_ch.last      = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        row_typed       = 1'b0;
        row_want        = '0;
        rst_n           = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            if (dir_rows[i].kind == ROW_CFG)
            begin
                settle();
                cfg_write(dir_rows[i].reg_idx, dir_rows[i].value);
            end
            else
                put_req(dir_rows[i].value[7:0], dir_rows[i].has_byte, dir_rows[i].last,
                        dir_rows[i].typed, dir_rows[i].want);

        // random strings; a phase may end mid-string so the new settings apply to its tail
        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       lim = 16'd1;
                1:       lim = 16'hFFFF;
                2:       lim = MAX_LEN_RESET;
                3:       lim = 16'($urandom_range(1, 65535));
                default: lim = 16'($urandom_range(2, 24));
            endcase
            settle();
            cfg_write(CFG_MAX_LEN, lim);
            cfg_write(CFG_LINK_MODE, 16'($urandom_range(0, 1)));
            if (phase == 2)
                hold_off_req = 1'b1;
            phase_end = items_sent + $urandom_range(100, 300);
            while (items_sent < phase_end)
            begin
                compose_path();
                send_path(1'b1);
            end
            if ($urandom_range(0, 2) == 0)
            begin
                compose_path();
                send_path(1'b0);
            end
            phase++;
        end

        put_req(CHAR_NUL, 1'b0, 1'b1);

        @(negedge clk);
        in_ch.valid <= 1'b0;
        for (n = 0; n < END_WAIT_CYCLES && verdicts_due.size() != 0; n++)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (verdicts_due.size() != 0)
            log_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
        if (mismatch_count == 0)
            $display("archive_path_safety_checker verification clean");
        else
            $display("archive_path_safety_checker verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_TIME);
        $display("timeout at %0t", $time);
        $display("archive_path_safety_checker verification failed");
        $finish;
    end

endmodule
